// ===== hw/rtl/idll_pkg.sv =====
// Shared types and codes for the indexed doubly linked list unit.
package idll_pkg;

  localparam int INDEX_W = 11;

  typedef struct packed {
    logic [2:0]         kind;
    logic [INDEX_W-1:0] index;
    logic signed [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
  } out_item_t;

  localparam logic [2:0] KIND_READ    = 3'd0;
  localparam logic [2:0] KIND_INS_HD  = 3'd1;
  localparam logic [2:0] KIND_INS_TL  = 3'd2;
  localparam logic [2:0] KIND_INS_AT  = 3'd3;
  localparam logic [2:0] KIND_DELETE  = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture request, start walk at head
    logic step;       // advance current node to fetched forward link
    logic read_done;  // emit read result from fetched data
    logic ins_alloc;  // read free-list link and succ back link, then take slot
    logic ins_link;   // write new node and neighbor links
    logic del_link;   // unlink victim
    logic finish_st;  // emit result with status; read value all ones for a read, else zero
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic at_target;
    logic in_range_rd;  // index < count
    logic in_range_ins; // index <= count
    logic full;
    logic at_end;       // index == count
  } dp_stat_t;

endpackage

// ===== hw/rtl/idll_ram.sv =====
// Generic single-port RAM with registered read.
module idll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read one entry a cycle, and write it as well when we is high
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/idll_dp.sv =====
// Datapath: node memories, list registers and result registers.
module idll_dp #(
  parameter int CAPACITY   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  idll_pkg::in_item_t  req,
  input  idll_pkg::ctl_cmd_t  cmd,
  input  logic [1:0]          sub,
  output idll_pkg::dp_stat_t  stat,
  output logic                out_valid,
  output idll_pkg::out_item_t out_item
);

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = AW + 1;
  localparam logic [PW-1:0] NUL = PW'(CAPACITY);
  localparam int XW = (PW > idll_pkg::INDEX_W) ? PW : idll_pkg::INDEX_W;

  logic [PW-1:0] head_r, tail_r, cnt_r, fresh_r, free_r;
  logic [PW-1:0] cur_r, pos_r, slot_r, pred_r;
  idll_pkg::in_item_t req_r;
  logic out_valid_r;
  idll_pkg::out_item_t out_r;

  logic             d_we, f_we, b_we;
  logic [AW-1:0]    d_a, f_a, b_a;
  logic [DATA_WIDTH-1:0] d_wd, d_rd;
  logic [PW-1:0]    f_wd, f_rd, b_wd, b_rd;

  idll_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_data (
    .clk, .we(d_we), .addr(d_a), .wdata(d_wd), .rdata(d_rd));
  idll_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_fwd (
    .clk, .we(f_we), .addr(f_a), .wdata(f_wd), .rdata(f_rd));
  idll_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_back (
    .clk, .we(b_we), .addr(b_a), .wdata(b_wd), .rdata(b_rd));

  logic [PW-1:0] idx_ext;
  logic [XW-1:0] idx_w, cnt_w;
  logic [PW-1:0] succ;
  assign idx_ext = PW'(req_r.index);
  // compare index and count at full width so large indexes never alias
  assign idx_w = XW'(req_r.index);
  assign cnt_w = XW'(cnt_r);
  // successor of new node: head, null, or walked node
  always_comb begin
    case (req_r.kind)
      idll_pkg::KIND_INS_HD: succ = head_r;
      idll_pkg::KIND_INS_TL: succ = NUL;
      default:               succ = (idx_w == cnt_w) ? NUL : cur_r;
    endcase
  end

  // Status for the controller
  always_comb begin
    stat.at_target    = (pos_r == idx_ext);
    stat.in_range_rd  = (idx_w < cnt_w);
    stat.in_range_ins = (idx_w <= cnt_w);
    stat.full         = (cnt_r >= NUL);
    stat.at_end       = (idx_w == cnt_w);
  end

  // Memory port control; sub selects the write phase of a multi-write step
  always_comb begin
    d_we = 1'b0; f_we = 1'b0; b_we = 1'b0;
    d_a = cur_r[AW-1:0]; f_a = cur_r[AW-1:0]; b_a = cur_r[AW-1:0];
    d_wd = DATA_WIDTH'(req_r.item_value);
    f_wd = succ; b_wd = pred_r;
    if (cmd.ins_alloc) begin
      f_a = free_r[AW-1:0];
      b_a = succ[AW-1:0];
    end
    if (cmd.ins_link) begin
      case (sub)
        2'd0: begin
          d_we = 1'b1; f_we = 1'b1; b_we = 1'b1;
          d_a = slot_r[AW-1:0]; f_a = slot_r[AW-1:0]; b_a = slot_r[AW-1:0];
        end
        default: begin
          f_we = (pred_r != NUL); f_a = pred_r[AW-1:0]; f_wd = slot_r;
          b_we = (succ != NUL);   b_a = succ[AW-1:0];   b_wd = slot_r;
        end
      endcase
    end
    if (cmd.del_link) begin
      case (sub)
        2'd0: begin
          f_we = (b_rd != NUL); f_a = b_rd[AW-1:0]; f_wd = f_rd;
          b_we = (f_rd != NUL); b_a = f_rd[AW-1:0]; b_wd = b_rd;
        end
        default: begin
          f_we = 1'b1; f_a = cur_r[AW-1:0]; f_wd = free_r;
        end
      endcase
    end
  end

  logic [31:0] rv_ext;
  assign rv_ext = 32'(signed'(d_rd));

  // List registers and walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= NUL; tail_r <= NUL; cnt_r <= '0; fresh_r <= '0; free_r <= NUL;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cmd.load) begin
        req_r <= req; cur_r <= head_r; pos_r <= '0;
      end
      if (cmd.step) begin
        cur_r <= f_rd; pos_r <= pos_r + 1'b1;
      end
      // sub 0 reads the free link and succ back link; sub 1 takes the slot
      if (cmd.ins_alloc && sub != 2'd0) begin
        if (free_r != NUL) begin
          slot_r <= free_r; free_r <= f_rd;
        end else begin
          slot_r <= fresh_r; fresh_r <= fresh_r + 1'b1;
        end
        pred_r <= (succ == NUL) ? tail_r : b_rd;
      end
      if (cmd.ins_link && sub != 2'd0) begin
        if (succ == NUL) tail_r <= slot_r;
        if (pred_r == NUL) head_r <= slot_r;
        cnt_r <= cnt_r + 1'b1;
        out_valid_r <= 1'b1;
        out_r <= '{read_value: '0, status: idll_pkg::ST_DONE};
      end
      if (cmd.del_link && sub == 2'd0) begin
        if (b_rd == NUL) head_r <= f_rd;
        if (f_rd == NUL) tail_r <= b_rd;
      end
      if (cmd.del_link && sub != 2'd0) begin
        free_r <= cur_r; cnt_r <= cnt_r - 1'b1;
        out_valid_r <= 1'b1;
        out_r <= '{read_value: '0, status: idll_pkg::ST_DONE};
      end
      if (cmd.read_done) begin
        out_valid_r <= 1'b1;
        out_r <= '{read_value: rv_ext, status: idll_pkg::ST_DONE};
      end
      if (cmd.finish_st) begin
        out_valid_r <= 1'b1;
        case (req_r.kind)
          idll_pkg::KIND_READ:
            out_r <= '{read_value: '1, status: idll_pkg::ST_RANGE};
          idll_pkg::KIND_DELETE:
            out_r <= '{read_value: '0, status: idll_pkg::ST_RANGE};
          idll_pkg::KIND_INS_AT:
            out_r <= '{read_value: '0, status: stat.in_range_ins ?
                       idll_pkg::ST_FULL : idll_pkg::ST_RANGE};
          idll_pkg::KIND_INS_HD, idll_pkg::KIND_INS_TL:
            out_r <= '{read_value: '0, status: idll_pkg::ST_FULL};
          default:
            out_r <= '{read_value: '0, status: idll_pkg::ST_DONE};
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= NUL)
    else $error("entry count above capacity");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (head_r == NUL && tail_r == NUL))
    else $error("empty list with live pointers");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("back-to-back results");
`endif

endmodule

// ===== hw/rtl/idll_ctrl.sv =====
// Controller state machine sequencing list requests.
module idll_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  idll_pkg::in_item_t req,
  input  idll_pkg::dp_stat_t stat,
  output idll_pkg::ctl_cmd_t cmd,
  output logic [1:0]         sub,
  output logic               busy
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DISP  = 8'b0000_0010,
    S_WALK  = 8'b0000_0100,
    S_WAIT  = 8'b0000_1000,
    S_ACT   = 8'b0001_0000,
    S_ALLOC = 8'b0010_0000,
    S_LINK  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic [2:0] kind_r;

  // Hold the request kind for branching
  always_ff @(posedge clk) begin
    if (start && !busy) kind_r <= req.kind;
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r; sub_nxt = sub_r; cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1; state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        sub_nxt = '0;
        case (kind_r)
          idll_pkg::KIND_READ, idll_pkg::KIND_DELETE:
            state_nxt = stat.in_range_rd ? S_WALK : S_OUT;
          idll_pkg::KIND_INS_HD, idll_pkg::KIND_INS_TL:
            state_nxt = stat.full ? S_OUT : S_ALLOC;
          idll_pkg::KIND_INS_AT:
            state_nxt = (!stat.in_range_ins || stat.full) ? S_OUT :
                        (stat.at_end ? S_ALLOC : S_WALK);
          default: state_nxt = S_OUT;
        endcase
      end
      // issue read of current node
      S_WALK: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (stat.at_target) begin
          state_nxt = S_ACT;
        end else begin
          cmd.step = 1'b1; state_nxt = S_WALK;
        end
      end
      S_ACT: begin
        case (kind_r)
          idll_pkg::KIND_READ: begin
            cmd.read_done = 1'b1; state_nxt = S_IDLE;
          end
          idll_pkg::KIND_DELETE: begin
            cmd.del_link = 1'b1; sub_nxt = sub_r + 1'b1;
            if (sub_r != 2'd0) state_nxt = S_IDLE;
          end
          default: state_nxt = S_ALLOC;
        endcase
      end
      // sub 0: issue reads of free link and succ back link; sub 1: capture
      S_ALLOC: begin
        cmd.ins_alloc = 1'b1;
        if (sub_r == 2'd0) begin
          sub_nxt = 2'd1;
        end else begin
          sub_nxt = '0; state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        cmd.ins_link = 1'b1; sub_nxt = sub_r + 1'b1;
        if (sub_r != 2'd0) state_nxt = S_IDLE;
      end
      S_OUT: begin
        cmd.finish_st = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; sub_r <= '0;
    end else begin
      state_r <= state_nxt; sub_r <= sub_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign sub  = sub_r;

`ifndef SYNTH
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == S_IDLE))
    else $error("load outside idle");
  a_walk_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |=> (state_r == S_WAIT))
    else $error("walk read not followed by wait");
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.read_done, cmd.finish_st, cmd.load}))
    else $error("conflicting commands");
`endif

endmodule

// ===== hw/rtl/indexed_doubly_linked_list_unit.sv =====
// Top level of the indexed doubly linked list unit.
// One request per transfer: start is taken when busy is low, and exactly one result
// appears for one cycle on out_valid, in the cycle busy drops. Out-of-range, full and
// unused kinds go straight to the result; head, tail and append inserts allocate and
// link without a walk. Positional requests walk the forward links from the head,
// one node per WALK and WAIT state pair, since each link comes through a registered
// memory read. The receiver cannot stall; results must be taken when strobed.
module indexed_doubly_linked_list_unit #(
  parameter int CAPACITY   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  idll_pkg::in_item_t  in_item,
  output logic                out_valid,
  output idll_pkg::out_item_t out_item
);

  idll_pkg::ctl_cmd_t cmd;
  idll_pkg::dp_stat_t stat;
  logic [1:0] sub;

  idll_ctrl u_ctrl (
    .clk, .rst_n, .start, .req(in_item), .stat, .cmd, .sub, .busy);

  idll_dp #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk, .rst_n, .req(in_item), .cmd, .sub, .stat, .out_valid, .out_item);

endmodule
